// ===== src/lsmf_pkg.sv =====
// Shared types, constants and sector codes for the lidar sector mean filter.
package lsmf_pkg;

    // Scan limits and derived widths
    localparam int MAX_SAMPLES = 4096;
    localparam int IDX_W       = $clog2(MAX_SAMPLES + 1);
    localparam int RANGE_W     = 16;
    localparam int MEAN_W      = 16;
    localparam int START_W     = 20;
    localparam int STEP_W      = 13;
    localparam int PROD_W      = IDX_W + STEP_W;
    localparam int ANGLE_W     = ((PROD_W > START_W) ? PROD_W : START_W) + 2;
    localparam int SUM_W       = $clog2(MAX_SAMPLES) + RANGE_W;
    localparam int CNT_W       = IDX_W;
    localparam int CFG_W       = 20;
    localparam int CFG_IDX_W   = 2;

    // Step counter width of the mean divider
    localparam int DIV_CNT_W   = $clog2(MEAN_W);

    // Sector boundaries, Q16 radians
    localparam int ANG_PI6  = 34315;
    localparam int ANG_2PI6 = 68629;
    localparam int ANG_4PI6 = 137258;
    localparam int ANG_5PI6 = 171573;

    // Sector codes, also the bit positions of the empty mask
    localparam int SECTORS = 4;
    localparam int SEC_W   = 2;
    localparam logic [SEC_W-1:0] SEC_FRONT = 2'd0;
    localparam logic [SEC_W-1:0] SEC_BACK  = 2'd1;
    localparam logic [SEC_W-1:0] SEC_LEFT  = 2'd2;
    localparam logic [SEC_W-1:0] SEC_RIGHT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEIL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [START_W-1:0] START_ANGLE_RST = START_W'(-205887);
    localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = STEP_W'(1608);
    localparam logic [RANGE_W-1:0] RANGE_CEIL_RST  = RANGE_W'(12000);
    localparam logic [RANGE_W-1:0] MIN_RANGE_RST   = RANGE_W'(150);

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               is_infinite;
        logic               last;
    } sample_t;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_front;
        logic [MEAN_W-1:0]  mean_back;
        logic [MEAN_W-1:0]  mean_left;
        logic [MEAN_W-1:0]  mean_right;
        logic [SECTORS-1:0] empty_mask;
    } result_t;

    // Classified sample leaving the front end
    typedef struct packed {
        logic               valid;
        logic               acc;
        logic               last;
        logic [SEC_W-1:0]   sector;
        logic [RANGE_W-1:0] range_mm;
    } req_t;

    // One sector memory entry
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } entry_t;

endpackage

// ===== src/lsmf_front.sv =====
// Front end: configuration registers, sample index, angle and sector classification.
module lsmf_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lsmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsmf_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              accept,
    input  lsmf_pkg::sample_t                 sample,
    output lsmf_pkg::req_t                    req
);

    logic [lsmf_pkg::START_W-1:0] start_reg;
    logic [lsmf_pkg::STEP_W-1:0]  step_reg;
    logic [lsmf_pkg::RANGE_W-1:0] ceil_reg;
    logic [lsmf_pkg::RANGE_W-1:0] min_reg;

    logic [lsmf_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                         s1_valid_reg;
    logic                         s1_acc_reg, s1_acc_next;
    logic                         s1_last_reg;
    logic [lsmf_pkg::RANGE_W-1:0] s1_range_reg, s1_range_next;
    logic [lsmf_pkg::PROD_W-1:0]  s1_prod_reg, s1_prod_next;

    logic                         in_window;
    logic signed [lsmf_pkg::ANGLE_W-1:0] angle;
    logic                         hit;
    logic [lsmf_pkg::SEC_W-1:0]   sector;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= lsmf_pkg::START_ANGLE_RST;
            step_reg  <= lsmf_pkg::ANGLE_STEP_RST;
            ceil_reg  <= lsmf_pkg::RANGE_CEIL_RST;
            min_reg   <= lsmf_pkg::MIN_RANGE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lsmf_pkg::REG_START_ANGLE: start_reg <= cfg_data[lsmf_pkg::START_W-1:0];
                lsmf_pkg::REG_ANGLE_STEP:  step_reg  <= cfg_data[lsmf_pkg::STEP_W-1:0];
                lsmf_pkg::REG_RANGE_CEIL:  ceil_reg  <= cfg_data[lsmf_pkg::RANGE_W-1:0];
                lsmf_pkg::REG_MIN_RANGE:   min_reg   <= cfg_data[lsmf_pkg::RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Select range, test it and form the angle offset of the accepted word
    always_comb
    begin
        in_window     = (idx_reg < lsmf_pkg::IDX_W'(lsmf_pkg::MAX_SAMPLES));
        s1_range_next = sample.is_infinite ? ceil_reg : sample.range_mm;
        s1_acc_next   = in_window && (s1_range_next >= min_reg);
        s1_prod_next  = lsmf_pkg::PROD_W'(idx_reg) * lsmf_pkg::PROD_W'(step_reg);
        idx_next      = idx_reg;
        if (accept)
        begin
            if (sample.last)
                idx_next = '0;
            else if (in_window)
                idx_next = idx_reg + lsmf_pkg::IDX_W'(1);
        end
    end

    // Advance index and first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_acc_reg   <= s1_acc_next;
            s1_last_reg  <= sample.last;
            s1_range_reg <= s1_range_next;
            s1_prod_reg  <= s1_prod_next;
        end
    end

    // Form the angle and sort it into a sector
    always_comb
    begin
        angle = $signed({{(lsmf_pkg::ANGLE_W - lsmf_pkg::START_W){start_reg[lsmf_pkg::START_W-1]}},
                         start_reg})
              + $signed({{(lsmf_pkg::ANGLE_W - lsmf_pkg::PROD_W){1'b0}}, s1_prod_reg});
        hit    = 1'b1;
        sector = lsmf_pkg::SEC_FRONT;
        if (angle >= $signed(-lsmf_pkg::ANGLE_W'(lsmf_pkg::ANG_PI6)) &&
            angle <= $signed(lsmf_pkg::ANGLE_W'(lsmf_pkg::ANG_PI6)))
            sector = lsmf_pkg::SEC_BACK;
        else if (angle >= $signed(-lsmf_pkg::ANGLE_W'(lsmf_pkg::ANG_4PI6)) &&
                 angle <= $signed(-lsmf_pkg::ANGLE_W'(lsmf_pkg::ANG_2PI6)))
            sector = lsmf_pkg::SEC_LEFT;
        else if (angle >= $signed(lsmf_pkg::ANGLE_W'(lsmf_pkg::ANG_2PI6)) &&
                 angle <= $signed(lsmf_pkg::ANGLE_W'(lsmf_pkg::ANG_4PI6)))
            sector = lsmf_pkg::SEC_RIGHT;
        else if (angle <= $signed(-lsmf_pkg::ANGLE_W'(lsmf_pkg::ANG_5PI6)) ||
                 angle >= $signed(lsmf_pkg::ANGLE_W'(lsmf_pkg::ANG_5PI6)))
            sector = lsmf_pkg::SEC_FRONT;
        else
            hit = 1'b0;

        req.valid    = s1_valid_reg;
        req.acc      = s1_valid_reg && s1_acc_reg && hit;
        req.last     = s1_last_reg;
        req.sector   = sector;
        req.range_mm = s1_range_reg;
    end

endmodule

// ===== src/lsmf_divider.sv =====
// Restoring divider: one quotient bit per cycle, for one sector mean.
module lsmf_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lsmf_pkg::SUM_W-1:0]     dividend,
    input  logic [lsmf_pkg::CNT_W-1:0]     divisor,
    output logic                           done,
    output logic [lsmf_pkg::MEAN_W-1:0]    quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [lsmf_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [lsmf_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic [lsmf_pkg::MEAN_W-1:0]     low_reg, low_next;
    logic [lsmf_pkg::CNT_W-1:0]      div_reg, div_next;
    logic [lsmf_pkg::CNT_W:0]        cand;
    logic [lsmf_pkg::CNT_W:0]        diff;
    logic                            ge;

    // Shift in one dividend bit and try the subtraction
    always_comb
    begin
        cand      = {rem_reg, low_reg[lsmf_pkg::MEAN_W-1]};
        diff      = cand - {1'b0, div_reg};
        ge        = (cand >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        div_next  = div_reg;
        if (start)
        begin
            // Quotient fits the mean width, so the upper dividend bits seed the remainder
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = lsmf_pkg::CNT_W'(dividend[lsmf_pkg::SUM_W-1:lsmf_pkg::MEAN_W]);
            low_next  = dividend[lsmf_pkg::MEAN_W-1:0];
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[lsmf_pkg::CNT_W-1:0] : cand[lsmf_pkg::CNT_W-1:0];
            low_next = {low_reg[lsmf_pkg::MEAN_W-2:0], ge};
            cnt_next = cnt_reg + lsmf_pkg::DIV_CNT_W'(1);
            if (cnt_reg == lsmf_pkg::DIV_CNT_W'(lsmf_pkg::MEAN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

// ===== src/lidar_sector_mean_filter_core.sv =====
// Top level: sector memory with read-modify-write, end-of-scan sequencer and result register.
//
// Sample channel: sample_valid / sample_stall / sample carry one range word per
// cycle. A word is taken on a rising edge with sample_valid high and sample_stall
// low. Result channel: result_valid / result_stall / result; one result word is
// given for each word marked last, with the four sector means and the empty mask.
// Configuration: cfg_write with cfg_index and cfg_data writes one register per
// edge; write only while no scan word is in flight.
// Throughput: one word per cycle during a scan. Sector sums and counts live in a
// four-entry memory read in the cycle before the write, with forwarding between
// back-to-back words of the same sector.
// Scan end: after a last word the input is stalled through the pipeline drain,
// then per sector one memory read, one load and the 16-step shared divider with
// its done cycle, then the load of the result register, which waits while a
// held result is stalled. The result word is valid from the edge ending that
// load, and the input reopens at the same edge.
// Reset clears the sample index, the sector valid bits (all sums and counts read
// as zero) and restores the register defaults. A stalled result holds; the next
// scan accumulates meanwhile, and its end waits until the register is free.
module lidar_sector_mean_filter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lsmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsmf_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  lsmf_pkg::sample_t                 sample,
    output logic                              result_valid,
    input  logic                              result_stall,
    output lsmf_pkg::result_t                 result
);

    typedef enum logic [4:0] {
        ST_ACC  = 5'b00001,
        ST_READ = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic                            drain_reg, drain_next;
    logic [lsmf_pkg::SEC_W-1:0]      sec_reg, sec_next;
    logic                            accept;
    lsmf_pkg::req_t                  req;

    // Sector memory and its access path
    lsmf_pkg::entry_t                mem [lsmf_pkg::SECTORS];
    lsmf_pkg::entry_t                rd_data_reg;
    lsmf_pkg::entry_t                fwd_data_reg;
    logic                            fwd_hit_reg;
    logic                            rd_live_reg;
    logic [lsmf_pkg::SECTORS-1:0]    valid_reg, valid_next;
    logic [lsmf_pkg::SEC_W-1:0]      rd_addr;
    lsmf_pkg::entry_t                base;
    lsmf_pkg::entry_t                wr_entry;
    logic                            ram_we;

    // Second stage
    logic                            s2_valid_reg;
    logic                            s2_acc_reg;
    logic                            s2_last_reg;
    logic [lsmf_pkg::SEC_W-1:0]      s2_sector_reg;
    logic [lsmf_pkg::RANGE_W-1:0]    s2_range_reg;

    // Scan end
    logic                            div_start;
    logic                            div_done;
    logic [lsmf_pkg::MEAN_W-1:0]     div_quot;
    logic [lsmf_pkg::MEAN_W-1:0]     mean_reg [lsmf_pkg::SECTORS];
    logic [lsmf_pkg::SECTORS-1:0]    mask_reg;
    logic                            out_load;
    logic                            result_valid_reg, result_valid_next;
    lsmf_pkg::result_t               result_reg;

    assign sample_stall = (state_reg != ST_ACC) || drain_reg;
    assign accept       = sample_valid && !sample_stall;

    lsmf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .sample    (sample),
        .req       (req)
    );

    // Read address: classified word while scanning, sector counter at scan end
    assign rd_addr = (state_reg == ST_READ) ? sec_reg : req.sector;

    // Pick the old entry: forwarded write, stored entry, or zero when never written
    always_comb
    begin
        if (fwd_hit_reg)
            base = fwd_data_reg;
        else if (rd_live_reg)
            base = rd_data_reg;
        else
            base = '0;
        wr_entry.sum   = base.sum + lsmf_pkg::SUM_W'(s2_range_reg);
        wr_entry.count = base.count + lsmf_pkg::CNT_W'(1);
        ram_we         = s2_valid_reg && s2_acc_reg;
    end

    // Write back and read the next entry
    always_ff @(posedge clk)
    begin
        if (ram_we)
            mem[s2_sector_reg] <= wr_entry;
        rd_data_reg  <= mem[rd_addr];
        fwd_hit_reg  <= ram_we && (s2_sector_reg == rd_addr);
        fwd_data_reg <= wr_entry;
        rd_live_reg  <= valid_reg[rd_addr];
    end

    // Advance second stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        s2_acc_reg    <= req.acc;
        s2_last_reg   <= req.last;
        s2_sector_reg <= req.sector;
        s2_range_reg  <= req.range_mm;
    end

    lsmf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (base.sum),
        .divisor  (base.count),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequence the scan end
    always_comb
    begin
        state_next        = state_reg;
        drain_next        = drain_reg;
        sec_next          = sec_reg;
        valid_next        = valid_reg;
        div_start         = 1'b0;
        out_load          = 1'b0;
        result_valid_next = result_valid_reg && result_stall;
        if (ram_we)
            valid_next[s2_sector_reg] = 1'b1;
        case (state_reg)
            ST_ACC:
            begin
                if (accept && sample.last)
                    drain_next = 1'b1;
                if (s2_valid_reg && s2_last_reg)
                begin
                    drain_next = 1'b0;
                    sec_next   = lsmf_pkg::SEC_FRONT;
                    state_next = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (sec_reg == lsmf_pkg::SEC_RIGHT)
                        state_next = ST_OUT;
                    else
                    begin
                        sec_next   = sec_reg + lsmf_pkg::SEC_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load          = 1'b1;
                    result_valid_next = 1'b1;
                    valid_next        = '0;
                    state_next        = ST_ACC;
                end
            end
            default:
                state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_ACC;
            drain_reg        <= 1'b0;
            sec_reg          <= lsmf_pkg::SEC_FRONT;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            drain_reg        <= drain_next;
            sec_reg          <= sec_next;
            valid_reg        <= valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Hold per-sector means and empty flags
    always_ff @(posedge clk)
    begin
        if (div_start)
            mask_reg[sec_reg] <= (base.count == '0);
        if (div_done)
            mean_reg[sec_reg] <= mask_reg[sec_reg] ? '0 : div_quot;
        if (out_load)
        begin
            result_reg.mean_front <= mean_reg[lsmf_pkg::SEC_FRONT];
            result_reg.mean_back  <= mean_reg[lsmf_pkg::SEC_BACK];
            result_reg.mean_left  <= mean_reg[lsmf_pkg::SEC_LEFT];
            result_reg.mean_right <= mean_reg[lsmf_pkg::SEC_RIGHT];
            result_reg.empty_mask <= mask_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Memory is written only while accumulating
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_ACC))
        else $error("sector memory written outside accumulation");

    // A last word leaving the pipeline starts the sector readout
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg)
            |=> (state_reg == ST_READ) && (sec_reg == lsmf_pkg::SEC_FRONT))
        else $error("scan end did not start readout");

    // Loading a result clears every sector for the next scan
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (valid_reg == '0) && result_valid_reg)
        else $error("sector state not cleared after result load");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    // No word follows a last word into the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg) |-> !req.valid)
        else $error("word followed a last word into the pipeline");

endmodule
